### rtl/pfra_pkg.sv
package pfra_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_ALLOC  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [31:0] AVAILABLE_TYPE = 32'd1;
    localparam logic [63:0] RESET_MIN_ADDR = 64'h0000_0000_0010_0000;

    localparam int IN_W  = 160;
    localparam int OUT_W = 624;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADD1,
        ST_ADD2,
        ST_ADD3,
        ST_ADD4,
        ST_SEED,
        ST_TEST,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic add1;
        logic add2;
        logic add3;
        logic add4;
        logic seed;
        logic step;
        logic grant;
        logic set_empty;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic frames_zero;
        logic cursor_end;
        logic hit;
    } sts_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

### rtl/physical_frame_range_allocator_top.sv
// Physical frame range allocator. Each input item carries an operation in s_tuser
// (clear, add a memory-map entry, or allocate one frame) and yields exactly one
// result item with a status, the per-entry classification and the running totals
// as they stand after the operation. The entry end address is formed as the item is
// taken; an add then runs four datapath steps: the byte totals, the policy length
// and frame alignment, the slot and range checks, and the range store. Its result
// then loads the output register once that register is empty or being read. A
// clear makes one clear step, and an unknown operation goes straight to its result.
// An allocation seeds the cursor unless already seeded and tests for frames left.
// It then makes one registered read of the range table and one compare step for
// every range the cursor passes over; with no frames left it stops after the test.
// The block works on one item at a time: the next item is taken in the cycle after
// a result is loaded, and it may be taken while that result still waits on the
// output register. The range table has no reset; only entries below the
// stored-range count are ever read. The user must write the minimum usable address
// through the cfg channel only while the block is idle; the block does not check it.
module physical_frame_range_allocator_top #(
    parameter int REGION_SLOTS = 128,
    parameter int RANGE_SLOTS  = 128,
    parameter int FRAME_SHIFT  = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // region_base [63:0], region_length [127:64], region_type [159:128]
    input  logic [159:0] s_tdata,
    // operation [1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status [1:0], entry_flags [3:2], policy_length [67:4],
    // range_start_frame [119:68], range_frame_count [172:120], frame_addr [236:173],
    // raw_usable_total [300:237], raw_reserved_total [364:301],
    // policy_usable_total [428:365], top_usable_end [492:429],
    // eligible_frames_total [556:493], remaining_frames [620:557], zero [623:621]
    output logic [623:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    // min_usable_addr
    input  logic [63:0]  cfg_data
);

    pfra_pkg::cmd_t cmd;
    pfra_pkg::sts_t sts;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    pfra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfra_dp #(
        .REGION_SLOTS (REGION_SLOTS),
        .RANGE_SLOTS  (RANGE_SLOTS),
        .FRAME_SHIFT  (FRAME_SHIFT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_op      (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

endmodule

### rtl/pfra_ctrl.sv
module pfra_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic [1:0]         s_op,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  pfra_pkg::sts_t     sts,
    output pfra_pkg::cmd_t     cmd
);

    pfra_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfra_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            pfra_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    case (s_op)
                        pfra_pkg::OP_CLEAR: state_next = pfra_pkg::ST_CLEAR;
                        pfra_pkg::OP_ADD:   state_next = pfra_pkg::ST_ADD1;
                        pfra_pkg::OP_ALLOC: state_next = pfra_pkg::ST_SEED;
                        default:            state_next = pfra_pkg::ST_DONE;
                    endcase
                end
            end
            pfra_pkg::ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = pfra_pkg::ST_DONE;
            end
            pfra_pkg::ST_ADD1:
            begin
                cmd.add1   = 1'b1;
                state_next = pfra_pkg::ST_ADD2;
            end
            pfra_pkg::ST_ADD2:
            begin
                cmd.add2   = 1'b1;
                state_next = pfra_pkg::ST_ADD3;
            end
            pfra_pkg::ST_ADD3:
            begin
                cmd.add3   = 1'b1;
                state_next = pfra_pkg::ST_ADD4;
            end
            pfra_pkg::ST_ADD4:
            begin
                cmd.add4   = 1'b1;
                state_next = pfra_pkg::ST_DONE;
            end
            pfra_pkg::ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = pfra_pkg::ST_TEST;
            end
            pfra_pkg::ST_TEST:
            begin
                if (sts.frames_zero)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = pfra_pkg::ST_DONE;
                end
                else
                begin
                    state_next = pfra_pkg::ST_READ;
                end
            end
            pfra_pkg::ST_READ:
            begin
                state_next = pfra_pkg::ST_CHECK;
            end
            pfra_pkg::ST_CHECK:
            begin
                if (sts.cursor_end)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = pfra_pkg::ST_DONE;
                end
                else if (sts.hit)
                begin
                    cmd.grant  = 1'b1;
                    state_next = pfra_pkg::ST_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = pfra_pkg::ST_READ;
                end
            end
            pfra_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = pfra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfra_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign s_tready = (state_reg == pfra_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

### rtl/pfra_dp.sv
module pfra_dp #(
    parameter int REGION_SLOTS = 128,
    parameter int RANGE_SLOTS  = 128,
    parameter int FRAME_SHIFT  = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pfra_pkg::IN_W-1:0]    s_tdata,
    input  logic [1:0]                   s_op,
    input  logic                         cfg_valid,
    input  logic [63:0]                  cfg_data,
    input  pfra_pkg::cmd_t               cmd,
    output pfra_pkg::sts_t               sts,
    output logic [pfra_pkg::OUT_W-1:0]   m_tdata
);

    localparam int AW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam logic [63:0] FMASK = (64'd1 << FRAME_SHIFT) - 64'd1;

    // Configuration and bookkeeping state.
    logic [63:0] min_addr_reg;
    logic [7:0]  slots_reg;
    logic [7:0]  ranges_reg;
    logic [63:0] usable_reg, reserved_reg, policy_reg, top_end_reg, frame_sum_reg;
    logic        seeded_reg, seed_pend_reg;
    logic [7:0]  cursor_reg;
    logic [52:0] nf_reg;
    logic [63:0] frames_left_reg;

    // Item being worked on and its intermediate values.
    logic [63:0] base_reg, len_reg;
    logic [31:0] type_reg;
    logic        base_lt_min_reg, ovf_reg;
    logic [63:0] end_reg, s_reg, sa_reg, rend_reg, diff_reg;
    logic        sa_ovf_reg, pol_ok_reg, region_ok_reg, range_ok_reg;

    // Result fields.
    logic [1:0]  status_reg, flags_reg;
    logic [63:0] plen_reg, faddr_reg;
    logic [51:0] rs_reg;
    logic [52:0] rc_reg;
    logic [pfra_pkg::OUT_W-1:0] out_reg;

    // Range tables.
    logic [51:0] start_mem [RANGE_SLOTS];
    logic [52:0] count_mem [RANGE_SLOTS];
    logic [51:0] rd_start_reg;
    logic [52:0] rd_count_reg;
    logic        wr_en;
    logic [51:0] wr_start;
    logic [52:0] wr_count;

    logic [64:0] end_sum, sa_sum;
    logic [63:0] ea;
    logic [52:0] base_nf, nf_max;
    logic [53:0] rng_end;
    logic        store_range;

    always_comb
    begin
        end_sum     = {1'b0, s_tdata[63:0]} + {1'b0, s_tdata[127:64]};
        sa_sum      = {1'b0, s_reg} + {1'b0, FMASK};
        ea          = rend_reg & ~FMASK;
        wr_start    = 52'(sa_reg >> FRAME_SHIFT);
        wr_count    = 53'(diff_reg >> FRAME_SHIFT);
        store_range = region_ok_reg && range_ok_reg && (ranges_reg < 8'(RANGE_SLOTS));
        wr_en       = cmd.add4 && store_range;
        base_nf     = seed_pend_reg ? {1'b0, rd_start_reg} : nf_reg;
        nf_max      = (base_nf < {1'b0, rd_start_reg}) ? {1'b0, rd_start_reg} : base_nf;
        rng_end     = {2'b0, rd_start_reg} + {1'b0, rd_count_reg};
        sts.frames_zero = (frames_left_reg == 64'd0);
        sts.cursor_end  = (cursor_reg >= ranges_reg);
        sts.hit         = (rd_count_reg != 53'd0) && ({1'b0, nf_max} < rng_end);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[ranges_reg[AW-1:0]] <= wr_start;
            count_mem[ranges_reg[AW-1:0]] <= wr_count;
        end
        rd_start_reg <= start_mem[cursor_reg[AW-1:0]];
        rd_count_reg <= count_mem[cursor_reg[AW-1:0]];
    end

    // Bookkeeping state with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_addr_reg    <= pfra_pkg::RESET_MIN_ADDR;
            slots_reg       <= '0;
            ranges_reg      <= '0;
            usable_reg      <= '0;
            reserved_reg    <= '0;
            policy_reg      <= '0;
            top_end_reg     <= '0;
            frame_sum_reg   <= '0;
            seeded_reg      <= 1'b0;
            seed_pend_reg   <= 1'b0;
            cursor_reg      <= '0;
            nf_reg          <= '0;
            frames_left_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_addr_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                slots_reg       <= '0;
                ranges_reg      <= '0;
                usable_reg      <= '0;
                reserved_reg    <= '0;
                policy_reg      <= '0;
                top_end_reg     <= '0;
                frame_sum_reg   <= '0;
                seeded_reg      <= 1'b0;
                seed_pend_reg   <= 1'b0;
                cursor_reg      <= '0;
                nf_reg          <= '0;
                frames_left_reg <= '0;
            end
            if (cmd.add1)
            begin
                if (type_reg == pfra_pkg::AVAILABLE_TYPE)
                begin
                    usable_reg <= pfra_pkg::sat_add(usable_reg, len_reg);
                end
                else
                begin
                    reserved_reg <= pfra_pkg::sat_add(reserved_reg, len_reg);
                end
            end
            if (cmd.add3)
            begin
                if (plen_reg != 64'd0)
                begin
                    policy_reg <= pfra_pkg::sat_add(policy_reg, plen_reg);
                    if (rend_reg > top_end_reg)
                    begin
                        top_end_reg <= rend_reg;
                    end
                end
                if (slots_reg < 8'(REGION_SLOTS))
                begin
                    slots_reg <= slots_reg + 8'd1;
                end
            end
            if (wr_en)
            begin
                ranges_reg    <= ranges_reg + 8'd1;
                frame_sum_reg <= pfra_pkg::sat_add(frame_sum_reg, {11'd0, wr_count});
            end
            if (cmd.seed && !seeded_reg)
            begin
                cursor_reg      <= '0;
                nf_reg          <= '0;
                frames_left_reg <= frame_sum_reg;
                seeded_reg      <= 1'b1;
                seed_pend_reg   <= 1'b1;
            end
            if (cmd.step)
            begin
                nf_reg        <= (rd_count_reg == 53'd0) ? base_nf : nf_max;
                cursor_reg    <= cursor_reg + 8'd1;
                seed_pend_reg <= 1'b0;
            end
            if (cmd.grant)
            begin
                nf_reg          <= nf_max + 53'd1;
                frames_left_reg <= frames_left_reg - 64'd1;
                seed_pend_reg   <= 1'b0;
            end
            if (cmd.set_empty)
            begin
                seed_pend_reg <= 1'b0;
            end
        end
    end

    // Item fields, intermediates and result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg   <= s_tdata[63:0];
            len_reg    <= s_tdata[127:64];
            type_reg   <= s_tdata[159:128];
            end_reg    <= end_sum[63:0];
            ovf_reg    <= end_sum[64] && (s_op == pfra_pkg::OP_ADD);
            status_reg <= pfra_pkg::STATUS_OK;
            flags_reg  <= '0;
            plen_reg   <= '0;
            faddr_reg  <= '0;
            rs_reg     <= '0;
            rc_reg     <= '0;
        end
        if (cmd.add1)
        begin
            flags_reg[0]    <= (type_reg == pfra_pkg::AVAILABLE_TYPE);
            base_lt_min_reg <= (base_reg < min_addr_reg);
            s_reg           <= (base_reg < min_addr_reg) ? min_addr_reg : base_reg;
            rend_reg        <= ovf_reg ? {64{1'b1}} : end_reg;
            pol_ok_reg      <= (type_reg == pfra_pkg::AVAILABLE_TYPE) && (len_reg != 64'd0)
                               && !ovf_reg && (end_reg > min_addr_reg);
        end
        if (cmd.add2)
        begin
            if (pol_ok_reg)
            begin
                plen_reg     <= base_lt_min_reg ? (end_reg - min_addr_reg) : len_reg;
                flags_reg[1] <= 1'b1;
            end
            sa_reg     <= sa_sum[63:0] & ~FMASK;
            sa_ovf_reg <= sa_sum[64];
        end
        if (cmd.add3)
        begin
            region_ok_reg <= (slots_reg < 8'(REGION_SLOTS));
            range_ok_reg  <= flags_reg[1] && (rend_reg > s_reg) && !sa_ovf_reg && (ea > sa_reg);
            diff_reg      <= ea - sa_reg;
            if (slots_reg >= 8'(REGION_SLOTS))
            begin
                status_reg <= pfra_pkg::STATUS_FULL;
            end
        end
        if (cmd.add4 && region_ok_reg && range_ok_reg)
        begin
            if (store_range)
            begin
                rs_reg <= wr_start;
                rc_reg <= wr_count;
            end
            else
            begin
                status_reg <= pfra_pkg::STATUS_FULL;
            end
        end
        if (cmd.grant)
        begin
            if ((64'(nf_max) >> (64 - FRAME_SHIFT)) != 64'd0)
            begin
                status_reg <= pfra_pkg::STATUS_EMPTY;
            end
            else
            begin
                faddr_reg <= 64'(nf_max) << FRAME_SHIFT;
            end
        end
        if (cmd.set_empty)
        begin
            status_reg <= pfra_pkg::STATUS_EMPTY;
        end
        if (cmd.emit)
        begin
            out_reg <= {3'd0, frames_left_reg, frame_sum_reg, top_end_reg, policy_reg,
                        reserved_reg, usable_reg, faddr_reg, rc_reg, rs_reg, plen_reg,
                        flags_reg, status_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

### rtl/pfra_checker.sv
module pfra_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [623:0] m_tdata
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] <= pfra_pkg::STATUS_EMPTY)
        else $error("undefined status code");

    a_empty_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == pfra_pkg::STATUS_EMPTY |-> m_tdata[236:173] == 64'd0)
        else $error("frame address given with no-frame status");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("policy flag without raw flag");

    a_plen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3] == (m_tdata[67:4] != 64'd0))
        else $error("policy length disagrees with policy flag");

endmodule

bind physical_frame_range_allocator_top pfra_checker u_pfra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
